// ----- rtl/core/rap_pkg.sv -----
// Package for the reverse-and-add palindrome block: widths, codes, config struct,
// sequencer states and the reciprocal table of the shared digit divider.
// No dependencies.
`default_nettype none

package rap_pkg;

   localparam int MAX_DIGITS  = 32;
   localparam int VALUE_BITS  = 31;

   localparam int BASE_W      = 4;
   localparam int DIGIT_W     = 4;
   localparam int ITER_W      = 10;
   localparam int STATUS_W    = 2;
   localparam int DCNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int REM_W       = DIGIT_W + 1;
   localparam int RECIP_W     = VALUE_BITS + 1;
   localparam int HORNER_W    = VALUE_BITS + BASE_W;

   localparam int CSR_COUNT   = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_BYTE_W  = 2;
   localparam int CSR_INDEX_W = $clog2(CSR_COUNT);
   localparam int CSR_ADDR_W  = CSR_INDEX_W + CSR_BYTE_W;

   localparam logic [BASE_W-1:0] BASE_MIN       = 4'd2;
   localparam logic [BASE_W-1:0] BASE_MAX       = 4'd10;
   localparam logic [BASE_W-1:0] BASE_RESET     = 4'd10;
   localparam logic [ITER_W-1:0] MAX_ITER_RESET = 10'd100;
   localparam logic [DCNT_W-1:0] TARGET_DIGITS  = DCNT_W'(10);
   localparam logic [DCNT_W-1:0] ONE_DIGIT      = DCNT_W'(1);
   localparam logic [DCNT_W-1:0] DIGIT_LIMIT    = DCNT_W'(MAX_DIGITS);

   localparam logic [RECIP_W:0]  RECIP_NUM      = {1'b1, {RECIP_W{1'b0}}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NUMBER_BASE  = 3'd0,
      CSR_MIN_ITER     = 3'd1,
      CSR_MAX_ITER     = 3'd2,
      CSR_TARGET_MODE  = 3'd3,
      CSR_TARGET_VALUE = 3'd4
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_NONE     = 2'd0,
      STATUS_FOUND    = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_FIX,
      ST_ACC,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [BASE_W-1:0]     number_base;
      logic [ITER_W-1:0]     min_iterations;
      logic [ITER_W-1:0]     max_iterations;
      logic                  target_mode;
      logic [VALUE_BITS-1:0] target_value;
   } cfg_type;

   // floor(2^RECIP_W / base); quotient estimate is exact or one low
   function automatic logic [RECIP_W-1:0] recip_of(input logic [BASE_W-1:0] b);
      unique case (b)
         4'd2:    return RECIP_W'(RECIP_NUM / 2);
         4'd3:    return RECIP_W'(RECIP_NUM / 3);
         4'd4:    return RECIP_W'(RECIP_NUM / 4);
         4'd5:    return RECIP_W'(RECIP_NUM / 5);
         4'd6:    return RECIP_W'(RECIP_NUM / 6);
         4'd7:    return RECIP_W'(RECIP_NUM / 7);
         4'd8:    return RECIP_W'(RECIP_NUM / 8);
         4'd9:    return RECIP_W'(RECIP_NUM / 9);
         default: return RECIP_W'(RECIP_NUM / 10);
      endcase
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rap_req_if.sv -----
// Request channel: valid/ready handshake carrying the start number.
// Depends on rap_pkg.
`default_nettype none

interface rap_req_if import rap_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] start_value;

   modport source (output valid, output start_value, input ready);
   modport sink   (input valid, input start_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rap_rsp_if.sv -----
// Response channel: valid/ready handshake carrying status, palindrome and count.
// Depends on rap_pkg.
`default_nettype none

interface rap_rsp_if import rap_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [VALUE_BITS-1:0] palindrome_value;
   logic [ITER_W-1:0]     iteration_count;

   modport source (output valid, output status, output palindrome_value,
                   output iteration_count, input ready);
   modport sink   (input valid, input status, input palindrome_value,
                   input iteration_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/reverse_and_add_palindrome.sv -----
// Top level of the reverse-and-add palindrome search in a configurable base.
// Depends on rap_pkg, rap_req_if, rap_rsp_if, rap_csr and rap_digit_unit.
//
//   port       | dir | handshake          | contents
//   req_chan   | in  | valid/ready        | start_value
//   rsp_chan   | out | valid/ready        | status, palindrome_value, iteration_count
//   APB        | in  | psel/penable/pready| number_base .. target_value
//
// Each digit passes the shared divide unit in the states multiply, correct and
// accumulate; each iteration then checks the sum, and a transaction runs from
// idle through its iterations to done. req ready is high only when idle.
// A finished result waits in an output register; a new transaction is
// accepted meanwhile. Synchronous reset clears sequencer and output valid.
`default_nettype none

module reverse_and_add_palindrome import rap_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   rap_req_if.sink               req_chan,
   rap_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type               cfg;
   state_type             state_ff, state_in;

   logic [BASE_W-1:0]     base_ff, base_in, base_clamped;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  rev_ovf_ff, rev_ovf_in;
   logic [DCNT_W-1:0]     n_ff, n_in;
   logic [ITER_W-1:0]     iter_ff, iter_in;
   logic [DIGIT_W-1:0]    digit_ff, digit_in;

   status_type            res_status_ff, res_status_in;
   logic [VALUE_BITS-1:0] res_pal_ff, res_pal_in;
   logic [ITER_W-1:0]     res_cnt_ff, res_cnt_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff;
   logic [VALUE_BITS-1:0] rsp_pal_ff;
   logic [ITER_W-1:0]     rsp_cnt_ff;

   logic [VALUE_BITS-1:0] div_quotient;
   logic [DIGIT_W-1:0]    div_remainder;
   logic [HORNER_W-1:0]   horner;
   logic                  horner_ovf;
   logic [DCNT_W-1:0]     n_inc;
   logic                  digit_full;
   logic [VALUE_BITS:0]   sum;
   logic                  sum_ovf;
   logic                  too_long;
   logic                  accept_pal;
   logic                  last_iter;
   logic                  finish;
   logic                  slot_free;
   logic                  req_fire;

   rap_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rap_digit_unit u_digit (
      .clock     (clock),
      .dividend  (quo_ff),
      .base      (base_ff),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign base_clamped = (cfg.number_base < BASE_MIN) ? BASE_MIN :
                         (cfg.number_base > BASE_MAX) ? BASE_MAX : cfg.number_base;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && (state_ff == ST_IDLE);

   assign horner     = HORNER_W'(acc_ff) * HORNER_W'(base_ff) + HORNER_W'(digit_ff);
   assign horner_ovf = |horner[HORNER_W-1:VALUE_BITS];
   assign n_inc      = n_ff + ONE_DIGIT;
   assign digit_full = (n_inc == DIGIT_LIMIT);

   assign sum        = {1'b0, val_ff} + {1'b0, acc_ff};
   assign sum_ovf    = sum[VALUE_BITS];
   assign too_long   = cfg.target_mode && (n_ff >= TARGET_DIGITS);
   // reversal equals value exactly when the digit string mirrors
   assign accept_pal = !rev_ovf_ff && (acc_ff == val_ff) &&
                       (iter_ff >= cfg.min_iterations) &&
                       (!cfg.target_mode ||
                        ((n_ff > ONE_DIGIT) && (val_ff == cfg.target_value)));
   assign last_iter  = (iter_ff == cfg.max_iterations);
   assign finish     = too_long || accept_pal || rev_ovf_ff || sum_ovf || last_iter;

   assign slot_free  = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_chan.valid) state_in = ST_MUL;
         ST_MUL:   state_in = ST_FIX;
         ST_FIX:   state_in = ST_ACC;
         ST_ACC: begin
            if (quo_ff != '0) begin
               state_in = digit_full ? ST_DONE : ST_MUL;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: state_in = finish ? ST_DONE : ST_MUL;
         ST_DONE:  if (slot_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      base_in       = base_ff;
      val_in        = val_ff;
      quo_in        = quo_ff;
      acc_in        = acc_ff;
      rev_ovf_in    = rev_ovf_ff;
      n_in          = n_ff;
      iter_in       = iter_ff;
      digit_in      = digit_ff;
      res_status_in = res_status_ff;
      res_pal_in    = res_pal_ff;
      res_cnt_in    = res_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               base_in    = base_clamped;
               val_in     = req_chan.start_value;
               quo_in     = req_chan.start_value;
               acc_in     = '0;
               rev_ovf_in = 1'b0;
               n_in       = '0;
               iter_in    = '0;
            end
         end
         ST_MUL: begin
         end
         ST_FIX: begin
            quo_in   = div_quotient;
            digit_in = div_remainder;
         end
         ST_ACC: begin
            n_in = n_inc;
            if (!rev_ovf_ff) begin
               if (horner_ovf) begin
                  rev_ovf_in = 1'b1;
               end else begin
                  acc_in = horner[VALUE_BITS-1:0];
               end
            end
            if ((quo_ff != '0) && digit_full) begin
               res_status_in = STATUS_OVERFLOW;
               res_pal_in    = '0;
               res_cnt_in    = iter_ff;
            end
         end
         ST_CHECK: begin
            if (too_long) begin
               res_status_in = STATUS_NONE;
               res_pal_in    = '0;
               res_cnt_in    = '0;
            end else if (accept_pal) begin
               res_status_in = STATUS_FOUND;
               res_pal_in    = val_ff;
               res_cnt_in    = iter_ff;
            end else if (rev_ovf_ff || sum_ovf) begin
               res_status_in = STATUS_OVERFLOW;
               res_pal_in    = '0;
               res_cnt_in    = iter_ff;
            end else if (last_iter) begin
               res_status_in = STATUS_NONE;
               res_pal_in    = '0;
               res_cnt_in    = '0;
            end else begin
               val_in     = sum[VALUE_BITS-1:0];
               quo_in     = sum[VALUE_BITS-1:0];
               acc_in     = '0;
               rev_ovf_in = 1'b0;
               n_in       = '0;
               iter_in    = iter_ff + ITER_W'(1);
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_chan.ready) ||
                         ((state_ff == ST_DONE) && slot_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      val_ff        <= val_in;
      quo_ff        <= quo_in;
      acc_ff        <= acc_in;
      rev_ovf_ff    <= rev_ovf_in;
      n_ff          <= n_in;
      iter_ff       <= iter_in;
      digit_ff      <= digit_in;
      res_status_ff <= res_status_in;
      res_pal_ff    <= res_pal_in;
      res_cnt_ff    <= res_cnt_in;
      if ((state_ff == ST_DONE) && slot_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_pal_ff    <= res_pal_ff;
         rsp_cnt_ff    <= res_cnt_ff;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.palindrome_value = rsp_pal_ff;
   assign rsp_chan.iteration_count  = rsp_cnt_ff;

endmodule

`default_nettype wire

// ----- rtl/core/rap_csr.sv -----
// APB-style configuration registers of the palindrome block.
// Depends on rap_pkg.
`default_nettype none

module rap_csr import rap_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          write_en;

   assign pready   = 1'b1;
   assign index    = csr_index_type'(paddr[CSR_ADDR_W-1:CSR_BYTE_W]);
   assign write_en = psel && penable && pwrite;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            CSR_NUMBER_BASE:  cfg_in.number_base    = pwdata[BASE_W-1:0];
            CSR_MIN_ITER:     cfg_in.min_iterations = pwdata[ITER_W-1:0];
            CSR_MAX_ITER:     cfg_in.max_iterations = pwdata[ITER_W-1:0];
            CSR_TARGET_MODE:  cfg_in.target_mode    = pwdata[0];
            CSR_TARGET_VALUE: cfg_in.target_value   = pwdata[VALUE_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_NUMBER_BASE:  prdata = CSR_DATA_W'(cfg_ff.number_base);
         CSR_MIN_ITER:     prdata = CSR_DATA_W'(cfg_ff.min_iterations);
         CSR_MAX_ITER:     prdata = CSR_DATA_W'(cfg_ff.max_iterations);
         CSR_TARGET_MODE:  prdata = CSR_DATA_W'(cfg_ff.target_mode);
         CSR_TARGET_VALUE: prdata = CSR_DATA_W'(cfg_ff.target_value);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.number_base    <= BASE_RESET;
         cfg_ff.min_iterations <= '0;
         cfg_ff.max_iterations <= MAX_ITER_RESET;
         cfg_ff.target_mode    <= 1'b0;
         cfg_ff.target_value   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/rap_digit_unit.sv -----
// Shared divide-by-base unit: registered reciprocal multiply, then one
// correction step giving quotient and lowest digit. Depends on rap_pkg.
`default_nettype none

module rap_digit_unit import rap_pkg::*; (
   input  logic                  clock,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [BASE_W-1:0]     base,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [DIGIT_W-1:0]    remainder
);

   logic [VALUE_BITS+RECIP_W-1:0] product_ff;
   logic [VALUE_BITS+RECIP_W-1:0] product_in;
   logic [VALUE_BITS-1:0]         q_est;
   logic [REM_W-1:0]              q_times_base;
   logic [REM_W-1:0]              rem_est;
   logic [REM_W-1:0]              base_ext;
   logic                          fix;

   assign product_in   = (VALUE_BITS+RECIP_W)'(dividend) *
                         (VALUE_BITS+RECIP_W)'(recip_of(base));
   assign q_est        = product_ff[VALUE_BITS+RECIP_W-1:RECIP_W];
   assign base_ext     = REM_W'(base);
   // remainder estimate is below twice the base, so the low bits suffice
   assign q_times_base = REM_W'(q_est[REM_W-1:0] * base_ext);
   assign rem_est      = dividend[REM_W-1:0] - q_times_base;
   assign fix          = (rem_est >= base_ext);
   assign quotient     = q_est + VALUE_BITS'(fix);
   assign remainder    = fix ? DIGIT_W'(rem_est - base_ext) : DIGIT_W'(rem_est);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

`default_nettype wire
